// ===== rtl/core/pi_speed_loop_with_ramp_defines.svh =====
// ---------------------------------------------------------------------------
// pi_speed_loop_with_ramp_defines.svh
// Assertion macros used by the speed loop checker.
// ---------------------------------------------------------------------------
`ifndef PI_SPEED_LOOP_WITH_RAMP_DEFINES_SVH
`define PI_SPEED_LOOP_WITH_RAMP_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define PISL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define PISL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pisl_pkg.sv =====
// ---------------------------------------------------------------------------
// pisl_pkg
// Types, codes and helpers of the PI speed loop.
// ---------------------------------------------------------------------------
`default_nettype none

package pisl_pkg;

  // item modes
  localparam logic MODE_RUN   = 1'b0;
  localparam logic MODE_RESET = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN_DT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKING_ALLOWED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLED    = 3'd5;

  // 5 rpm in Q23.8
  localparam logic signed [31:0] BRAKE_SPEED_THRESHOLD = 32'sd1280;

  // half LSB of the Q30.32 -> Q15.16 conversion
  localparam logic signed [63:0] ROUND_HALF = 64'sd32768;

  localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
  localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

  typedef struct packed {
    logic              mode;
    logic signed [31:0] speed_target;
    logic signed [31:0] speed_measured;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] current_ref;
    logic              output_saturated;
    logic signed [31:0] speed_error;
    logic signed [31:0] ramped_target;
  } out_item_t;

  // what an item does to the loop state
  typedef struct packed {
    logic reset_item;  // clear integrator, load ramp
    logic run;         // run step with loop enabled
  } tag_t;

  // sideband carried down the pipe with each item
  typedef struct packed {
    tag_t              tag;
    logic signed [31:0] meas;
    logic signed [31:0] err;
    logic signed [31:0] ramp;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
    logic signed [48:0] r;
    if (x > SAT_HI) r = SAT_HI;
    else if (x < SAT_LO) r = SAT_LO;
    else r = x;
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pisl_ramp.sv =====
// ---------------------------------------------------------------------------
// pisl_ramp
// Ramped target state and speed error for one item.
// ---------------------------------------------------------------------------
`default_nettype none

module pisl_ramp
  import pisl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire in_item_t    item,
  input  wire logic        loop_enabled,
  input  wire logic [30:0] ramp_step,
  output side_t            side_q
);

  logic signed [31:0] ramp_r, ramp_nxt;
  logic signed [31:0] ramp_run;
  logic signed [32:0] up_sum, dn_sum, tgt33;
  logic signed [48:0] diff;
  side_t              side_r, side_nxt;
  tag_t               tag;

  always_comb begin
    tag.reset_item = (item.mode == MODE_RESET);
    tag.run        = (item.mode == MODE_RUN) && loop_enabled;

    tgt33  = 33'(item.speed_target);
    up_sum = 33'(ramp_r) + signed'({2'b00, ramp_step});
    dn_sum = 33'(ramp_r) - signed'({2'b00, ramp_step});

    if (ramp_step == 31'd0) begin
      ramp_run = item.speed_target;
    end else if (ramp_r < item.speed_target) begin
      ramp_run = (up_sum > tgt33) ? item.speed_target : up_sum[31:0];
    end else if (ramp_r > item.speed_target) begin
      ramp_run = (dn_sum < tgt33) ? item.speed_target : dn_sum[31:0];
    end else begin
      ramp_run = ramp_r;
    end

    if (tag.reset_item) ramp_nxt = item.speed_measured;
    else if (tag.run) ramp_nxt = ramp_run;
    else ramp_nxt = ramp_r;

    diff = 49'(ramp_nxt) - 49'(item.speed_measured);

    side_nxt.tag  = tag;
    side_nxt.meas = item.speed_measured;
    side_nxt.err  = tag.run ? sat32(diff) : 32'sd0;
    side_nxt.ramp = ramp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r <= 32'sd0;
    end else if (en) begin
      ramp_r <= ramp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
    end
  end

  assign side_q = side_r;

endmodule

`default_nettype wire

// ===== rtl/core/pisl_gain_mul.sv =====
// ---------------------------------------------------------------------------
// pisl_gain_mul
// Gain times error, Q30.32 product then round half up to Q15.16.
// ---------------------------------------------------------------------------
`default_nettype none

module pisl_gain_mul
  import pisl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en_mul,
  input  wire logic               en_rnd,
  input  wire logic signed [31:0] gain,
  input  wire logic signed [31:0] err,
  output logic signed [47:0]      q
);

  logic signed [63:0] prod_r, prod_nxt;
  logic signed [63:0] rnd;
  logic signed [47:0] q_r;

  assign prod_nxt = 64'(gain) * 64'(err);
  assign rnd      = prod_r + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_r <= prod_nxt;
    end
  end

  // arithmetic shift by 16 = floor
  always_ff @(posedge clk) begin
    if (en_rnd) begin
      q_r <= rnd[63:16];
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== rtl/core/pisl_integ.sv =====
// ---------------------------------------------------------------------------
// pisl_integ
// Integrator with anti-windup, output clamp, braking block, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module pisl_integ
  import pisl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire side_t              side,
  input  wire logic signed [47:0] p,
  input  wire logic signed [47:0] inc,
  input  wire logic [30:0]        current_limit,
  input  wire logic               braking_allowed,
  output out_item_t               res
);

  logic signed [31:0] integ_r, integ_nxt;
  logic signed [48:0] lim, sum1, unsat;
  logic signed [31:0] integ_c, integ_w, cur_c, cur_f;
  logic               sat, windup, brk;
  out_item_t          res_r, res_nxt;

  function automatic logic signed [31:0] clamp_lim(input logic signed [48:0] x,
                                                   input logic signed [48:0] l);
    logic signed [48:0] neg;
    logic signed [48:0] r;
    neg = -l;
    if (x < neg) r = neg;
    else if (x > l) r = l;
    else r = x;
    return r[31:0];
  endfunction

  always_comb begin
    lim     = signed'(49'(current_limit));
    sum1    = 49'(integ_r) + 49'(inc);
    integ_c = clamp_lim(sum1, lim);
    unsat   = 49'(p) + 49'(integ_c);
    cur_c   = clamp_lim(unsat, lim);
    sat     = (49'(cur_c) != unsat);

    // drop this step's increment when pushing further into the limit
    windup  = sat && (((cur_c > 32'sd0) && (side.err > 32'sd0)) ||
                      ((cur_c < 32'sd0) && (side.err < 32'sd0)));
    integ_w = windup ? sat32(49'(integ_c) - 49'(inc)) : integ_c;

    brk = !braking_allowed &&
          (((side.meas > BRAKE_SPEED_THRESHOLD) && (cur_c < 32'sd0)) ||
           ((side.meas < -BRAKE_SPEED_THRESHOLD) && (cur_c > 32'sd0)));
    cur_f = brk ? 32'sd0 : cur_c;

    if (side.tag.reset_item) integ_nxt = 32'sd0;
    else if (side.tag.run) integ_nxt = integ_w;
    else integ_nxt = integ_r;

    res_nxt.current_ref      = side.tag.run ? cur_f : 32'sd0;
    res_nxt.output_saturated = side.tag.run && sat;
    res_nxt.speed_error      = side.err;
    res_nxt.ramped_target    = side.ramp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= 32'sd0;
    end else if (en) begin
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== rtl/core/pi_speed_loop_with_ramp.sv =====
// ---------------------------------------------------------------------------
// pi_speed_loop_with_ramp
// PI speed regulator with target ramp, producing a current reference.
// ---------------------------------------------------------------------------
//
//  channel  | signals                          | beat
//  ---------+----------------------------------+---------------------------
//  in       | in_valid, in_ready, in_data      | mode, target, measured
//  out      | out_valid, out_ready, out_data   | current, sat, error, ramp
//  cfg      | cfg_we, cfg_index, cfg_wdata     | one register write
//
//  One beat in per cycle sustained while out_ready holds; each taken beat
//  passes input register, ramp, products, rounding, integrator/result.
//  The ramp and integrator loops each close inside a single stage, so
//  back-to-back beats see each other's state exactly.
//  Synchronous active-low reset clears the config, the ramp, the integrator
//  and all stage valids. Stalls propagate stage by stage: a stage takes a
//  new beat whenever it is empty or its successor can take one.
// ---------------------------------------------------------------------------
`default_nettype none

module pi_speed_loop_with_ramp
  import pisl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_wdata
);

  // configuration registers
  logic signed [31:0] prop_gain_r, integ_gain_dt_r;
  logic [30:0]        ramp_step_r, current_limit_r;
  logic               braking_allowed_r, loop_enabled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r       <= 32'sd0;
      integ_gain_dt_r   <= 32'sd0;
      ramp_step_r       <= 31'd0;
      current_limit_r   <= 31'd0;
      braking_allowed_r <= 1'b0;
      loop_enabled_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROP_GAIN:       prop_gain_r       <= cfg_wdata;
        CFG_INTEG_GAIN_DT:   integ_gain_dt_r   <= cfg_wdata;
        CFG_RAMP_STEP:       ramp_step_r       <= cfg_wdata[30:0];
        CFG_CURRENT_LIMIT:   current_limit_r   <= cfg_wdata[30:0];
        CFG_BRAKING_ALLOWED: braking_allowed_r <= cfg_wdata[0];
        CFG_LOOP_ENABLED:    loop_enabled_r    <= cfg_wdata[0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // ---- pipeline flow control -------------------------------------------
  // v1: input register, v2: after ramp, v3: products, v4: rounded terms,
  // out_valid_r: result register.
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy_out, rdy4, rdy3, rdy2, rdy1;
  logic adv1, adv2, adv3, adv4, accept;

  always_comb begin
    rdy_out = !out_valid_r || out_ready;
    adv4    = v4_r && rdy_out;
    rdy4    = !v4_r || rdy_out;
    adv3    = v3_r && rdy4;
    rdy3    = !v3_r || rdy4;
    adv2    = v2_r && rdy3;
    rdy2    = !v2_r || rdy3;
    adv1    = v1_r && rdy2;
    rdy1    = !v1_r || rdy2;
    accept  = in_valid && rdy1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) v1_r <= 1'b1;
      else if (adv1) v1_r <= 1'b0;
      if (adv1) v2_r <= 1'b1;
      else if (adv2) v2_r <= 1'b0;
      if (adv2) v3_r <= 1'b1;
      else if (adv3) v3_r <= 1'b0;
      if (adv3) v4_r <= 1'b1;
      else if (adv4) v4_r <= 1'b0;
      if (adv4) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // ---- input register ----------------------------------------------------
  in_item_t s1_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_data;
    end
  end

  // ---- ramp and error ----------------------------------------------------
  side_t s2, s3_r, s4_r;

  pisl_ramp u_ramp (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv1),
    .item         (s1_r),
    .loop_enabled (loop_enabled_r),
    .ramp_step    (ramp_step_r),
    .side_q       (s2)
  );

  // sideband follows the two multiplier stages
  always_ff @(posedge clk) begin
    if (adv2) s3_r <= s2;
    if (adv3) s4_r <= s3_r;
  end

  // ---- gain products, one multiplier per term ---------------------------
  logic signed [47:0] p_term, i_term;

  pisl_gain_mul u_mul_p (
    .clk    (clk),
    .en_mul (adv2),
    .en_rnd (adv3),
    .gain   (prop_gain_r),
    .err    (s2.err),
    .q      (p_term)
  );

  pisl_gain_mul u_mul_i (
    .clk    (clk),
    .en_mul (adv2),
    .en_rnd (adv3),
    .gain   (integ_gain_dt_r),
    .err    (s2.err),
    .q      (i_term)
  );

  // ---- integrator, clamps and result register ---------------------------
  pisl_integ u_integ (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (adv4),
    .side            (s4_r),
    .p               (p_term),
    .inc             (i_term),
    .current_limit   (current_limit_r),
    .braking_allowed (braking_allowed_r),
    .res             (out_data)
  );

  assign in_ready  = rdy1;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/pisl_checker.sv =====
// ---------------------------------------------------------------------------
// pisl_checker
// Port-level checks of the PI speed loop, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "pi_speed_loop_with_ramp_defines.svh"

module pisl_checker
  import pisl_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire out_item_t            out_data,
  input wire logic                 cfg_we,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [31:0]          cfg_wdata
);

  // shadow of the current limit, taken from the write port
  logic signed [31:0] lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= 32'sd0;
    end else if (cfg_we && (cfg_index == CFG_CURRENT_LIMIT)) begin
      lim_r <= signed'({1'b0, cfg_wdata[30:0]});
    end
  end

  `PISL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  `PISL_ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready, "input blocked with empty output")

  `PISL_ASSERT_IMPL(a_cur_in_limit, out_valid, (out_data.current_ref <= lim_r) && (out_data.current_ref >= -lim_r), "current reference beyond limit")

  `PISL_ASSERT_IMPL(a_sat_at_rail, out_valid && out_data.output_saturated, (out_data.current_ref == lim_r) || (out_data.current_ref == -lim_r) || (out_data.current_ref == 32'sd0), "saturated result off the rail")

endmodule

bind pi_speed_loop_with_ramp pisl_checker u_pisl_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_pi_speed_loop_with_ramp.sv =====
// ----------------------------------------------------------------------------
// tb_pi_speed_loop_with_ramp
// Self-checking bench for the PI speed loop with target ramp.
// A clocked driver feeds speed samples from a queue, a clocked monitor checks
// every current reference beat against an in-bench model of the ramp, the PI
// terms, the conditional anti-windup and the braking block. Phases change the
// gains, ramp, limit and enables, and vary sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_pi_speed_loop_with_ramp
  import pisl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // settling allowance once the queues and the predictions are empty
  localparam int SETTLE_CYCLES = 12;
  // cycles without any beat in or out before the run is declared hung
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 52;
  localparam int NUM_PHASES    = 12;
  localparam int TGT_SPAN      = 768000;   // +-3000 rpm in Q23.8

  // --------------------------------------------------------------------------
  // clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;

  always #10 clk = ~clk;

  pi_speed_loop_with_ramp i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // queues and bookkeeping
  // --------------------------------------------------------------------------
  // a pending speed sample; settle_first holds it back until every predicted
  // current reference has come out
  typedef struct {
    in_item_t beat;
    bit       settle_first;
  } speed_cmd_t;

  speed_cmd_t speed_cmd_q[$];     // samples not yet presented
  out_item_t  current_ref_q[$];   // predicted results, oldest first

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  mismatch_cnt   = 0;
  int  quiet_cycles   = 0;
  bit  cmd_taken      = 1'b0;     // set at the edge that took the input beat

  // model copy of the registers and the loop state
  longint k_prop    = 0;
  longint k_integ   = 0;
  longint ramp_inc  = 0;
  longint i_limit   = 0;
  bit     brake_ok  = 1'b0;
  bit     loop_on   = 1'b0;
  longint ramp_acc  = 0;
  longint integ_acc = 0;

  // random sequence planning: held target and a slowly following speed
  int plan_tgt  = 0;
  int plan_meas = 0;

  // --------------------------------------------------------------------------
  // model of the speed loop
  // --------------------------------------------------------------------------
  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint clamp_sym(input longint x, input longint lim);
    if (x < -lim) return -lim;
    if (x > lim) return lim;
    return x;
  endfunction

  // Q7.24 gain times Q23.8 error -> Q15.16 amps, round half up (floor shift)
  function automatic longint to_amps(input longint gain, input longint err);
    return (gain * err + 64'sd32768) >>> 16;
  endfunction

  function automatic out_item_t step_speed_loop(input in_item_t it);
    out_item_t r;
    longint    tgt, meas, err, p, inc, unsat, cur;
    bit        clipped;
    tgt     = longint'($signed(it.speed_target));
    meas    = longint'($signed(it.speed_measured));
    err     = 0;
    cur     = 0;
    clipped = 1'b0;
    if (it.mode == MODE_RESET) begin
      // reset beat: works even with the loop disabled
      integ_acc = 0;
      ramp_acc  = meas;
    end else if (loop_on) begin
      if (ramp_inc == 0) begin
        ramp_acc = tgt;
      end else if (ramp_acc < tgt) begin
        ramp_acc = (ramp_acc + ramp_inc > tgt) ? tgt : ramp_acc + ramp_inc;
      end else if (ramp_acc > tgt) begin
        ramp_acc = (ramp_acc - ramp_inc < tgt) ? tgt : ramp_acc - ramp_inc;
      end
      err       = clip32(ramp_acc - meas);
      p         = to_amps(k_prop, err);
      inc       = to_amps(k_integ, err);
      integ_acc = clamp_sym(integ_acc + inc, i_limit);
      unsat     = p + integ_acc;
      cur       = clamp_sym(unsat, i_limit);
      clipped   = (cur != unsat);
      // anti-windup: back out this step's increment, no re-clamp to the limit
      if (clipped && ((cur > 0 && err > 0) || (cur < 0 && err < 0)))
        integ_acc = clip32(integ_acc - inc);
      // braking block keeps the saturation flag as found above
      if (!brake_ok && ((meas > BRAKE_SPEED_THRESHOLD && cur < 0) ||
                        (meas < -BRAKE_SPEED_THRESHOLD && cur > 0)))
        cur = 0;
    end
    r.current_ref      = cur[31:0];
    r.output_saturated = clipped;
    r.speed_error      = err[31:0];
    r.ramped_target    = ramp_acc[31:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // register writes, only while the loop is idle
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_PROP_GAIN:       k_prop   = longint'($signed(val));
      CFG_INTEG_GAIN_DT:   k_integ  = longint'($signed(val));
      CFG_RAMP_STEP:       ramp_inc = longint'(val[30:0]);
      CFG_CURRENT_LIMIT:   i_limit  = longint'(val[30:0]);
      CFG_BRAKING_ALLOWED: brake_ok = val[0];
      CFG_LOOP_ENABLED:    loop_on  = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] pg, input logic [31:0] ig,
                            input logic [31:0] rs, input logic [31:0] cl,
                            input bit brk, input bit en);
    write_reg(CFG_PROP_GAIN, pg);
    write_reg(CFG_INTEG_GAIN_DT, ig);
    write_reg(CFG_RAMP_STEP, rs);
    write_reg(CFG_CURRENT_LIMIT, cl);
    write_reg(CFG_BRAKING_ALLOWED, {31'd0, brk});
    write_reg(CFG_LOOP_ENABLED, {31'd0, en});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for the input queue and the predictions to empty, then let the
  // pipe settle
  task automatic wait_settled();
    while (speed_cmd_q.size() != 0 || in_valid || current_ref_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int rand_span(input int r);
    return int'($urandom_range(2 * r)) - r;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(3))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  task automatic push_cmd(input logic mode, input int tgt, input int meas,
                          input bit settle);
    speed_cmd_t c;
    c.beat.mode           = mode;
    c.beat.speed_target   = tgt;
    c.beat.speed_measured = meas;
    c.settle_first        = settle;
    speed_cmd_q.push_back(c);
  endtask

  // mostly a plausible control sequence: held target, speed following it;
  // the rest is reset beats, full-range noise and extreme values
  task automatic push_random_cmd(input bit settle);
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      push_cmd(MODE_RESET, $urandom, (pick < 2) ? int'($urandom) : plan_meas, settle);
    end else if (pick < 13) begin
      push_cmd(MODE_RUN, $urandom, $urandom, settle);
    end else if (pick < 17) begin
      push_cmd(MODE_RUN, pick_extreme(), pick_extreme(), settle);
    end else begin
      if ($urandom_range(9) == 0) plan_tgt = rand_span(TGT_SPAN);
      if ($urandom_range(9) == 0) plan_meas = rand_span(3000);  // within about +-11.7 rpm, around the 5 rpm threshold
      else plan_meas = plan_meas + (plan_tgt - plan_meas) / 8 + rand_span(2560);
      push_cmd(MODE_RUN, plan_tgt, plan_meas, settle);
    end
  endtask

  task automatic random_config();
    logic [31:0] pg, ig, rs, cl;
    pg = ($urandom_range(3) == 0) ? $urandom : rand_span(1 << 26);
    ig = ($urandom_range(3) == 0) ? $urandom : rand_span(1 << 23);
    rs = ($urandom_range(3) == 0) ? 0 : $urandom_range(128000, 1);
    cl = ($urandom_range(4) == 0) ? ($urandom & 32'h7fff_ffff) : $urandom_range(50 << 16);
    set_config(pg, ig, rs, cl, 1'($urandom_range(1)), $urandom_range(7) != 0);
  endtask

  task automatic set_idle(input int sel);
    case (sel)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
      default: begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // input driver: changes at the falling edge, holds a beat until taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_speed
    speed_cmd_t nxt;
    if (rst_n && (!in_valid || cmd_taken)) begin
      if (speed_cmd_q.size() != 0 &&
          !(speed_cmd_q[0].settle_first && current_ref_q.size() != 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt = speed_cmd_q.pop_front();
        in_data  <= nxt.beat;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    cmd_taken = 1'b0;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // monitor: predict on each input beat, check each result beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_beats
    out_item_t want;
    if (rst_n) begin
      // predict first so a same-edge result still lines up with the oldest
      if (in_valid && in_ready) begin
        current_ref_q.push_back(step_speed_loop(in_data));
        cmd_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (current_ref_q.size() == 0) begin
          report_mismatch("result beat with no prediction pending");
        end else begin
          want = current_ref_q.pop_front();
          if (out_data.current_ref !== want.current_ref)
            report_mismatch($sformatf("current_ref got %0d want %0d",
                                      out_data.current_ref, want.current_ref));
          if (out_data.output_saturated !== want.output_saturated)
            report_mismatch($sformatf("output_saturated got %0b want %0b",
                                      out_data.output_saturated, want.output_saturated));
          if (out_data.speed_error !== want.speed_error)
            report_mismatch($sformatf("speed_error got %0d want %0d",
                                      out_data.speed_error, want.speed_error));
          if (out_data.ramped_target !== want.ramped_target)
            report_mismatch($sformatf("ramped_target got %0d want %0d",
                                      out_data.ramped_target, want.ramped_target));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without a beat on either side ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("hung: %0d cycles without a beat", quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    // synchronous reset, released at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part: 1.0 A/rpm, 0.25 A/rpm integral, 100 rpm ramp, 20 A,
    // no braking
    set_idle(0);
    set_config(32'd1 << 24, 32'd1 << 22, 32'd25600, 32'd20 << 16, 1'b0, 1'b1);
    push_cmd(MODE_RESET, 0, 0, 1'b0);
    push_cmd(MODE_RUN, 256000, 0, 1'b0);        // ramp up, output clamped, windup removed
    push_cmd(MODE_RUN, 256000, 0, 1'b0);
    push_cmd(MODE_RUN, -256000, 0, 1'b0);       // ramp reverses
    push_cmd(MODE_RUN, 0, 512000, 1'b0);        // negative current while spinning forward
    push_cmd(MODE_RUN, 0, -512000, 1'b0);       // positive current while spinning backward
    push_cmd(MODE_RUN, 0, 1280, 1'b0);          // exactly 5 rpm: not beyond the threshold
    push_cmd(MODE_RUN, 0, 1281, 1'b0);
    push_cmd(MODE_RUN, 0, -1280, 1'b0);
    push_cmd(MODE_RUN, 0, -1281, 1'b0);
    push_cmd(MODE_RUN, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);  // error saturates high
    push_cmd(MODE_RESET, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    push_cmd(MODE_RUN, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);  // ramp already at target
    push_cmd(MODE_RESET, -1, 32'sh8000_0000, 1'b0);
    push_cmd(MODE_RUN, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);  // error saturates low
    push_cmd(MODE_RUN, 0, 0, 1'b0);
    push_cmd(MODE_RESET, 0, 12800, 1'b0);
    push_cmd(MODE_RUN, 12800, 12700, 1'b0);     // small error, inside the limit
    push_cmd(MODE_RUN, 12800, 12800, 1'b0);     // zero error
    push_cmd(MODE_RUN, 12800, 12900, 1'b0);
    push_cmd(MODE_RESET, 0, 0, 1'b0);
    wait_settled();

    // random phases; the first four pin fixed register settings, but phase 2 draws random gains
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_config(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                      1'b1, 1'b1);
        1: set_config(32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd0, 1'b0, 1'b1);  // zero limit
        2: set_config($urandom, $urandom, 32'd2560, 32'd10 << 16, 1'b0, 1'b0);  // loop off
        3: set_config(32'd0, 32'd0, 32'd1, 32'd1, 1'b0, 1'b1);
        default: random_config();
      endcase
      set_idle(ph % 4);
      plan_tgt  = rand_span(TGT_SPAN);
      plan_meas = rand_span(512000);
      // each phase opens with a reset beat, then random beats follow
      push_cmd(MODE_RESET, $urandom, plan_meas, 1'b0);
      for (int i = 1; i < PHASE_ITEMS; i++)
        push_random_cmd((i % 40) == 20 || $urandom_range(49) == 0);
      wait_settled();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (current_ref_q.size() != 0)
      report_mismatch($sformatf("%0d predicted results never came out",
                                current_ref_q.size()));
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/pisl_pkg.sv
rtl/core/pisl_ramp.sv
rtl/core/pisl_gain_mul.sv
rtl/core/pisl_integ.sv
rtl/core/pi_speed_loop_with_ramp.sv
rtl/core/pisl_checker.sv
tb/sv/tb_pi_speed_loop_with_ramp.sv
